FILE: hw/rtl/crrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_pkg
// Shared widths, action codes and record types of the ring region manager.
// ----------------------------------------------------------------------------
package crrm_pkg;

   localparam int unsigned MAX_BUFFER_BYTES   = 65536;
   localparam int unsigned MIN_BUFFER_BYTES   = 4;
   localparam int unsigned RESET_BUFFER_BYTES = 4096;

   localparam int unsigned PTR_W = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int unsigned OFF_W = $clog2(MAX_BUFFER_BYTES);
   localparam int unsigned ACT_W = 4;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [OFF_W-1:0] off_type;
   typedef logic [ACT_W-1:0] act_code_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR         = 4'd0,
      ACT_RESERVE_WRITE = 4'd1,
      ACT_RESERVE_READ  = 4'd2,
      ACT_MARK_WRITTEN  = 4'd3,
      ACT_MARK_READ     = 4'd4,
      ACT_MARK_READ_WRAP = 4'd5,
      ACT_READ_UPTO     = 4'd6,
      ACT_REWIND        = 4'd7,
      ACT_TWO_SEGMENTS  = 4'd8
   } action_type;

   typedef struct packed {
      ptr_type read_pos;
      ptr_type write_pos;
      ptr_type wrap_mark;
   } ring_state_type;

   typedef struct packed {
      logic    status;
      off_type offset_a;
      ptr_type length_a;
      off_type offset_b;
      ptr_type length_b;
   } result_type;

endpackage

FILE: hw/rtl/crrm_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_state
// Pointer registers and the buffer size register, with write clamping.
// ----------------------------------------------------------------------------
module crrm_state import crrm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write,
   input  ptr_type        csr_data,
   input  logic           update,
   input  ring_state_type ring_next,
   output ring_state_type ring,
   output ptr_type        ring_bytes
);

   localparam ptr_type SIZE_MIN   = ptr_type'(MIN_BUFFER_BYTES);
   localparam ptr_type SIZE_MAX   = ptr_type'(MAX_BUFFER_BYTES);
   localparam ptr_type SIZE_RESET = ptr_type'(RESET_BUFFER_BYTES);

   ring_state_type ring_ff, ring_in;
   ptr_type        size_ff, size_in;

   always_comb begin
      ring_in = ring_ff;
      size_in = size_ff;
      if (csr_write) begin
         ring_in = '0;
         if (csr_data < SIZE_MIN) begin
            size_in = SIZE_MIN;
         end else if (csr_data > SIZE_MAX) begin
            size_in = SIZE_MAX;
         end else begin
            size_in = csr_data;
         end
      end else if (update) begin
         ring_in = ring_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '0;
         size_ff <= SIZE_RESET;
      end else begin
         ring_ff <= ring_in;
         size_ff <= size_in;
      end
   end

   assign ring       = ring_ff;
   assign ring_bytes = size_ff;

endmodule

FILE: hw/rtl/crrm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_step
// One action on the ring pointers: next pointers and the result record.
// ----------------------------------------------------------------------------
module crrm_step import crrm_pkg::*; (
   input  act_code_type   action,
   input  ptr_type        amount,
   input  ptr_type        position,
   input  ptr_type        ring_bytes,
   input  ring_state_type ring,
   output ring_state_type ring_next,
   output result_type     result
);

   localparam ptr_type WRAP_MIN_READ = ptr_type'(2);

   function automatic ptr_type sat_add(ptr_type a, ptr_type b, ptr_type size);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, size}) ? size : s[PTR_W-1:0];
   endfunction

   function automatic ptr_type clamp(ptr_type p, ptr_type size);
      return (p > size) ? size : p;
   endfunction

   function automatic ptr_type gap(ptr_type hi, ptr_type lo);
      return (hi > lo) ? ptr_type'(hi - lo - ptr_type'(1)) : '0;
   endfunction

   ptr_type rp, wp, wm;
   ptr_type half, pos, tail, room_wp, room, rd_rp, rd_wm, beyond;
   logic    wp_ahead;

   assign rp       = ring.read_pos;
   assign wp       = ring.write_pos;
   assign wm       = ring.wrap_mark;
   assign half     = ring_bytes >> 1;
   assign pos      = clamp(position, ring_bytes);
   assign wp_ahead = wp > rp;
   assign tail     = gap(ring_bytes, wp);
   assign room_wp  = wp_ahead ? '0 : wp;
   assign room     = gap(rp, room_wp);
   assign rd_rp    = (rp == wm) ? '0 : rp;
   assign rd_wm    = (rp == wm) ? '0 : wm;
   assign beyond   = (wm > rp) ? ptr_type'(wm - rp) : '0;

   always_comb begin
      ring_next = ring;
      result    = '0;
      case (action_type'(action))
         ACT_CLEAR: begin
            ring_next = '0;
         end
         ACT_RESERVE_WRITE: begin
            result.status = 1'b1;
            if (amount <= half) begin
               if (wm == '0 && rp == wp) begin
                  ring_next.read_pos  = '0;
                  ring_next.write_pos = '0;
                  result.status       = 1'b0;
                  result.length_a     = ptr_type'(ring_bytes - ptr_type'(1));
               end else if (wp_ahead && tail >= amount) begin
                  result.status   = 1'b0;
                  result.offset_a = wp[OFF_W-1:0];
                  result.length_a = tail;
               end else if (!wp_ahead || rp >= WRAP_MIN_READ) begin
                  if (wp_ahead) begin
                     ring_next.wrap_mark = wp;
                     ring_next.write_pos = '0;
                  end
                  if (room >= amount) begin
                     result.status   = 1'b0;
                     result.offset_a = room_wp[OFF_W-1:0];
                     result.length_a = room;
                  end
               end
            end
         end
         ACT_RESERVE_READ: begin
            ring_next.read_pos  = rd_rp;
            ring_next.wrap_mark = rd_wm;
            if (wp <= rd_rp && rd_rp < rd_wm) begin
               result.offset_a = rd_rp[OFF_W-1:0];
               result.length_a = ptr_type'(rd_wm - rd_rp);
            end else if (rd_rp < wp) begin
               result.offset_a = rd_rp[OFF_W-1:0];
               result.length_a = ptr_type'(wp - rd_rp);
            end else begin
               result.status = 1'b1;
            end
         end
         ACT_MARK_WRITTEN: begin
            ring_next.write_pos = sat_add(wp, amount, ring_bytes);
         end
         ACT_MARK_READ: begin
            ring_next.read_pos = sat_add(rp, amount, ring_bytes);
         end
         ACT_MARK_READ_WRAP: begin
            if (wm != '0 && amount >= beyond) begin
               ring_next.wrap_mark = '0;
               ring_next.read_pos  = clamp(ptr_type'(amount - beyond), ring_bytes);
            end else begin
               ring_next.read_pos = sat_add(rp, amount, ring_bytes);
            end
         end
         ACT_READ_UPTO: begin
            if (pos < rp) begin
               ring_next.wrap_mark = '0;
            end
            ring_next.read_pos = pos;
         end
         ACT_REWIND: begin
            if (pos > wp) begin
               ring_next.wrap_mark = '0;
            end
            ring_next.write_pos = pos;
         end
         ACT_TWO_SEGMENTS: begin
            if (rp == wm) begin
               result.length_a = wp;
            end else if (wp <= rp && rp < wm) begin
               result.offset_a = rp[OFF_W-1:0];
               result.length_a = ptr_type'(wm - rp);
               result.length_b = wp;
            end else if (rp < wp) begin
               result.offset_a = rp[OFF_W-1:0];
               result.length_a = ptr_type'(wp - rp);
            end
         end
         default: begin
            result.status = 1'b1;
         end
      endcase
   end

endmodule

FILE: hw/rtl/contiguous_ring_region_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_ring_region_manager
// Pointer keeper for a byte ring that grants contiguous regions only.
// ----------------------------------------------------------------------------
// One action is accepted every cycle unless a held result waits on rsp_ready.
// The action is held in an input register, worked on against the pointer
// registers, and its result is offered from an output register that also lets
// the next action enter while it waits. The sustained rate of one action per
// cycle is set by the update loop of the pointer registers. A write of the
// buffer size clears all pointers and is taken only while no action is held
// in the input register.
// ----------------------------------------------------------------------------
module contiguous_ring_region_manager import crrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  act_code_type req_action,
   input  ptr_type      req_amount,
   input  ptr_type      req_position,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_status,
   output off_type      rsp_offset_a,
   output ptr_type      rsp_length_a,
   output off_type      rsp_offset_b,
   output ptr_type      rsp_length_b,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  ptr_type      csr_data
);

   logic           req_valid_ff, req_valid_in;
   act_code_type   req_action_ff;
   ptr_type        req_amount_ff, req_position_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff;
   logic           advance;
   logic           req_take;
   ring_state_type ring, ring_next;
   ptr_type        ring_bytes;
   result_type     result;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign csr_ready    = !req_valid_ff;
   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   crrm_state u_state (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .update     (advance),
      .ring_next  (ring_next),
      .ring       (ring),
      .ring_bytes (ring_bytes)
   );

   crrm_step u_step (
      .action     (req_action_ff),
      .amount     (req_amount_ff),
      .position   (req_position_ff),
      .ring_bytes (ring_bytes),
      .ring       (ring),
      .ring_next  (ring_next),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff   <= req_action;
         req_amount_ff   <= req_amount;
         req_position_ff <= req_position;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_offset_a = rsp_ff.offset_a;
   assign rsp_length_a = rsp_ff.length_a;
   assign rsp_offset_b = rsp_ff.offset_b;
   assign rsp_length_b = rsp_ff.length_b;

endmodule

FILE: hw/rtl/crrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrm_checker
// Port-level checks of the ring region manager, bound to the top level.
// ----------------------------------------------------------------------------
module crrm_checker import crrm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input logic    rsp_status,
   input off_type rsp_offset_a,
   input ptr_type rsp_length_a,
   input off_type rsp_offset_b,
   input ptr_type rsp_length_b
);

   localparam logic [PTR_W:0] RING_END = (PTR_W + 1)'(MAX_BUFFER_BYTES);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_offset_a) && $stable(rsp_length_a)
         && $stable(rsp_offset_b) && $stable(rsp_length_b))
      else $error("result changed before its transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_second_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_b != '0 |-> !rsp_status && rsp_length_a != '0)
      else $error("second segment without a first one");

   a_region_in_ring: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((PTR_W + 1)'(rsp_offset_a) + (PTR_W + 1)'(rsp_length_a)) <= RING_END)
      else $error("region runs past the end of the ring");

endmodule

bind contiguous_ring_region_manager crrm_checker u_crrm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_offset_a (rsp_offset_a),
   .rsp_length_a (rsp_length_a),
   .rsp_offset_b (rsp_offset_b),
   .rsp_length_b (rsp_length_b)
);
